// File: sv/vrp_pkg.sv
package vrp_pkg;

  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;
  localparam logic [1:0] REG_FOCAL   = 2'd3;

  localparam int COEF_W = 18;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0][2:0] mat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: sv/vertex_rotate_project.sv
// Rotates a Q16.16 vertex by Rz*Ry*Rx and projects it as x*f/(f+z), y*f/(f+z).
// A new vertex is taken every cycle while full is low and results are taken as
// they appear; after the edge that accepts it, each one passes the second
// rotation stage, the four-beat queue, two setup stages, a 63-stage bit-per-stage
// divider and the output register. After reset and after any register write the
// matrix is rebuilt from the sine table by one shared multiplier, which holds
// full high until the matrix is ready.
module vertex_rotate_project #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic               zero_depth
);
  import vrp_pkg::*;

  logic [15:0]          angle_x;
  logic [15:0]          angle_y;
  logic [15:0]          angle_z;
  logic [31:0]          focal_distance;
  logic                 coef_ready;
  mat_t                 mat;
  logic [QUEUE_CW-1:0]  q_count;
  logic                 q_push;
  vec_t                 q_wdata;
  vec_t                 q_rdata;
  logic                 q_pop;
  logic                 q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x        <= 16'd182;
      angle_y        <= 16'd182;
      angle_z        <= 16'd182;
      focal_distance <= 32'd26214400;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ANGLE_X: angle_x        <= cfg_data[15:0];
        REG_ANGLE_Y: angle_y        <= cfg_data[15:0];
        REG_ANGLE_Z: angle_z        <= cfg_data[15:0];
        REG_FOCAL:   focal_distance <= cfg_data;
        default:     ;
      endcase
    end
  end

  vrp_coef #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_coef (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .ready   (coef_ready),
    .mat     (mat)
  );

  vrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .full       (full),
    .coef_ready (coef_ready),
    .mat        (mat),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  vrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  vrp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .focal_distance (focal_distance),
    .pop            (pop),
    .empty          (empty),
    .rot_x          (rot_x),
    .rot_y          (rot_y),
    .rot_z          (rot_z),
    .proj_x         (proj_x),
    .proj_y         (proj_y),
    .zero_depth     (zero_depth)
  );

endmodule

// File: sv/vrp_sine_rom.sv
module vrp_sine_rom #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr,
  output logic signed [16:0]   data
);

  function automatic logic signed [16:0] entry(input longint unsigned k);
    longint unsigned m;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned num;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint sum;
    longint r;
    m = 4 * k;
    q = m / DEPTH;
    rem = m % DEPTH;
    num = ((q & 1) != 0) ? DEPTH - rem : rem;
    t = (64'd1686629711 * num) / DEPTH;
    t2 = (t * t) >> 30;
    term = t;
    sum = longint'(t);
    term = ((term * t2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    if (r > 32768) r = 32768;
    return 17'((q >= 2) ? -r : r);
  endfunction

  logic signed [16:0] tbl [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
    assign tbl[k] = entry(k);
  end

  always_ff @(posedge clk) begin
    data <= tbl[addr];
  end

endmodule

// File: sv/vrp_coef.sv
module vrp_coef #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic [15:0]   angle_x,
  input  logic [15:0]   angle_y,
  input  logic [15:0]   angle_z,
  output logic          ready,
  output vrp_pkg::mat_t mat
);
  import vrp_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [4:0] MUL_FIRST = 5'd7;
  localparam logic [4:0] MUL_LAST  = 5'd20;
  localparam logic [4:0] LAST      = 5'd21;

  logic              busy;
  logic [4:0]        cnt;
  logic [15:0]       ang_base;
  logic [15:0]       ang;
  logic [AW-1:0]     rom_addr;
  logic signed [16:0] rom_data;
  logic signed [16:0] c [6];
  coef_t             p [14];
  logic [3:0]        job;
  logic [3:0]        mjob;
  logic              mval;
  logic signed [35:0] mprod;
  logic signed [35:0] rnd;
  coef_t             opa;
  coef_t             opb;

  // coefficient order: sx cx sy cy sz cz
  always_comb begin
    case (cnt[2:1])
      2'd0:    ang_base = angle_x;
      2'd1:    ang_base = angle_y;
      default: ang_base = angle_z;
    endcase
    ang = cnt[0] ? ang_base + 16'd16384 : ang_base;
    rom_addr = AW'((32'(ang) * 32'(SINE_TABLE_DEPTH)) >> 16);
  end

  vrp_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign job = 4'(cnt - MUL_FIRST);

  always_comb begin
    case (job)
      4'd0:    begin opa = COEF_W'(c[5]); opb = COEF_W'(c[3]); end
      4'd1:    begin opa = COEF_W'(c[5]); opb = COEF_W'(c[2]); end
      4'd2:    begin opa = COEF_W'(c[4]); opb = COEF_W'(c[3]); end
      4'd3:    begin opa = COEF_W'(c[4]); opb = COEF_W'(c[2]); end
      4'd4:    begin opa = COEF_W'(c[3]); opb = COEF_W'(c[0]); end
      4'd5:    begin opa = COEF_W'(c[3]); opb = COEF_W'(c[1]); end
      4'd6:    begin opa = COEF_W'(c[4]); opb = COEF_W'(c[1]); end
      4'd7:    begin opa = COEF_W'(c[4]); opb = COEF_W'(c[0]); end
      4'd8:    begin opa = COEF_W'(c[5]); opb = COEF_W'(c[1]); end
      4'd9:    begin opa = COEF_W'(c[5]); opb = COEF_W'(c[0]); end
      4'd10:   begin opa = p[1]; opb = COEF_W'(c[0]); end
      4'd11:   begin opa = p[1]; opb = COEF_W'(c[1]); end
      4'd12:   begin opa = p[3]; opb = COEF_W'(c[0]); end
      default: begin opa = p[3]; opb = COEF_W'(c[1]); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      cnt  <= '0;
      mval <= 1'b0;
    end else begin
      mval <= busy && cnt >= MUL_FIRST && cnt <= MUL_LAST;
      if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  assign rnd = (mprod + 36'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (busy && cnt >= 5'd1 && cnt <= 5'd6) c[3'(cnt - 5'd1)] <= rom_data;
    mprod <= 36'(opa * opb);
    mjob  <= job;
    if (mval) p[mjob] <= COEF_W'(rnd);
  end

  assign ready = !busy;

  always_comb begin
    mat[0][0] = p[0];
    mat[0][1] = p[10] - p[6];
    mat[0][2] = p[11] + p[7];
    mat[1][0] = p[2];
    mat[1][1] = p[12] + p[8];
    mat[1][2] = p[13] - p[9];
    mat[2][0] = -COEF_W'(c[2]);
    mat[2][1] = p[4];
    mat[2][2] = p[5];
  end

endmodule

// File: sv/vrp_front.sv
module vrp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic signed [31:0]                in_x,
  input  logic signed [31:0]                in_y,
  input  logic signed [31:0]                in_z,
  output logic                              full,
  input  logic                              coef_ready,
  input  vrp_pkg::mat_t                     mat,
  input  logic [vrp_pkg::QUEUE_CW-1:0]      q_count,
  output logic                              q_push,
  output vrp_pkg::vec_t                     q_data
);
  import vrp_pkg::*;

  logic               accept;
  logic signed [31:0] vin [3];
  logic signed [49:0] prod [3][3];
  logic               s1v;
  logic               s2v;
  logic signed [51:0] sum [3];
  logic signed [36:0] shf [3];
  logic signed [31:0] sat [3];
  vec_t               rot;

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // room for everything already in flight plus this beat
  assign full = !coef_ready ||
                (QUEUE_CW'(q_count + QUEUE_CW'(s1v) + QUEUE_CW'(s2v)) >= QUEUE_CW'(QUEUE_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= 50'(vin[j] * mat[i][j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 52'(prod[i][0]) + 52'(prod[i][1]) + 52'(prod[i][2]);
      shf[i] = 37'((sum[i] + 52'sd16384) >>> 15);
      if (shf[i] > 37'sd2147483647) sat[i] = 32'h7FFFFFFF;
      else if (shf[i] < -37'sd2147483648) sat[i] = 32'h80000000;
      else sat[i] = shf[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
    end else begin
      s1v <= accept;
      s2v <= s1v;
    end
  end

  always_ff @(posedge clk) begin
    rot.x <= sat[0];
    rot.y <= sat[1];
    rot.z <= sat[2];
  end

  assign q_push = s2v;
  assign q_data = rot;

endmodule

// File: sv/vrp_queue.sv
module vrp_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  vrp_pkg::vec_t                 wdata,
  input  logic                          rd,
  output vrp_pkg::vec_t                 rdata,
  output logic                          empty,
  output logic [vrp_pkg::QUEUE_CW-1:0]  count
);
  import vrp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  vec_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;

  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= PW'(wp + PW'(1));
      if (rd) rp <= PW'(rp + PW'(1));
      if (wr && !rd) count <= count + QUEUE_CW'(1);
      else if (rd && !wr) count <= count - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule

// File: sv/vrp_back.sv
module vrp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  vrp_pkg::vec_t      q_data,
  output logic               q_pop,
  input  logic [31:0]        focal_distance,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic               zero_depth
);
  import vrp_pkg::*;

  localparam int NSTEP = 63;

  typedef struct packed {
    vec_t        r;
    logic        zero;
    logic        neg_x;
    logic        neg_y;
    logic [32:0] d;
    logic [32:0] rem_x;
    logic [32:0] rem_y;
    logic [62:0] nq_x;
    logic [62:0] nq_y;
  } dstage_t;

  logic               adv;
  logic               out_valid;
  logic               v0;
  vec_t               r0;
  logic signed [63:0] nx0;
  logic signed [63:0] ny0;
  logic signed [33:0] den0;
  logic               vld [NSTEP+1];
  dstage_t            ds  [NSTEP+1];
  dstage_t            nxt [NSTEP];
  dstage_t            fin;
  logic signed [31:0] px;
  logic signed [31:0] py;

  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;
  assign fin   = ds[NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      for (int i = 0; i <= NSTEP; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0     <= !q_empty;
      vld[0] <= v0;
      for (int i = 0; i < NSTEP; i++) vld[i+1] <= vld[i];
      out_valid <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0   <= q_data;
      nx0  <= 64'(q_data.x * $signed({1'b0, focal_distance}));
      ny0  <= 64'(q_data.y * $signed({1'b0, focal_distance}));
      den0 <= $signed({2'b00, focal_distance}) + 34'(q_data.z);
      ds[0].r     <= r0;
      ds[0].zero  <= (den0 == '0);
      ds[0].neg_x <= nx0[63] ^ den0[33];
      ds[0].neg_y <= ny0[63] ^ den0[33];
      ds[0].d     <= den0[33] ? 33'(-den0) : den0[32:0];
      ds[0].rem_x <= '0;
      ds[0].rem_y <= '0;
      ds[0].nq_x  <= nx0[63] ? 63'(-nx0) : nx0[62:0];
      ds[0].nq_y  <= ny0[63] ? 63'(-ny0) : ny0[62:0];
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    logic [33:0] tx;
    logic [33:0] ty;
    logic        gx;
    logic        gy;
    always_comb begin
      tx = {ds[k].rem_x, ds[k].nq_x[62]};
      ty = {ds[k].rem_y, ds[k].nq_y[62]};
      gx = tx >= {1'b0, ds[k].d};
      gy = ty >= {1'b0, ds[k].d};
      nxt[k]       = ds[k];
      nxt[k].rem_x = gx ? 33'(tx - {1'b0, ds[k].d}) : tx[32:0];
      nxt[k].rem_y = gy ? 33'(ty - {1'b0, ds[k].d}) : ty[32:0];
      nxt[k].nq_x  = {ds[k].nq_x[61:0], gx};
      nxt[k].nq_y  = {ds[k].nq_y[61:0], gy};
    end
    always_ff @(posedge clk) begin
      if (adv) ds[k+1] <= nxt[k];
    end
  end

  always_comb begin
    if (fin.zero) px = 32'h7FFFFFFF;
    else if (fin.neg_x) px = (fin.nq_x > 63'd2147483648) ? 32'h80000000 : 32'(-fin.nq_x);
    else px = (fin.nq_x > 63'd2147483647) ? 32'h7FFFFFFF : fin.nq_x[31:0];
    if (fin.zero) py = 32'h7FFFFFFF;
    else if (fin.neg_y) py = (fin.nq_y > 63'd2147483648) ? 32'h80000000 : 32'(-fin.nq_y);
    else py = (fin.nq_y > 63'd2147483647) ? 32'h7FFFFFFF : fin.nq_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_x      <= fin.r.x;
      rot_y      <= fin.r.y;
      rot_z      <= fin.r.z;
      proj_x     <= px;
      proj_y     <= py;
      zero_depth <= fin.zero;
    end
  end

endmodule

// File: bench/vertex_rotate_project_tb.sv
module vertex_rotate_project_tb;
  import vrp_pkg::*;

  localparam int  ROM_DEPTH   = 1024;
  localparam int  IDLE_LIMIT  = 5000;
  localparam int  DRAIN_WAIT  = 100;
  localparam int  MAX_SHOWN   = 10;

  typedef struct {
    int   rx;
    int   ry;
    int   rz;
    int   px;
    int   py;
    logic zd;
  } vertex_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ANGLE_X;
  logic [31:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_z = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic signed [31:0] rot_x, rot_y, rot_z, proj_x, proj_y;
  logic        zero_depth;

  int          sine_tab [ROM_DEPTH];
  logic [15:0] cur_ax, cur_ay, cur_az;
  logic [31:0] cur_focal;
  vertex_out_t expected_q [$];
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          zero_depth_seen = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          stall_req = 1'b0;
  int          hold_cnt = 0;
  int          pop_gap = 0;

  vertex_rotate_project #(.SINE_TABLE_DEPTH(ROM_DEPTH)) u_dut (.*);

  always #10 clk = ~clk;

  function automatic int sine_entry(int k);
    longint unsigned d, m, q, rem, num, t, t2, term;
    longint sum, r;
    d = ROM_DEPTH;
    m = 4 * k;
    q = m / d;
    rem = m % d;
    num = q[0] ? d - rem : rem;
    t = (64'd1686629711 * num) / d;
    t2 = (t * t) >> 30;
    term = t;
    sum = t;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    if (r > 32768) r = 32768;
    return (q >= 2) ? -int'(r) : int'(r);
  endfunction

  function automatic longint sin_of(logic [15:0] a);
    return sine_tab[(32'(a) * ROM_DEPTH) >> 16];
  endfunction

  function automatic longint cos_of(logic [15:0] a);
    return sin_of(a + 16'd16384);
  endfunction

  function automatic longint round_q(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint q15_mul(longint a, longint b);
    return round_q(a * b, 15);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic vertex_out_t transform_vertex(int vx, int vy, int vz);
    longint sx, cx, sy, cy, sz, cz, den;
    longint m [3][3];
    longint v [3];
    longint r [3];
    vertex_out_t o;
    sx = sin_of(cur_ax); cx = cos_of(cur_ax);
    sy = sin_of(cur_ay); cy = cos_of(cur_ay);
    sz = sin_of(cur_az); cz = cos_of(cur_az);
    m[0][0] = q15_mul(cz, cy);
    m[0][1] = q15_mul(q15_mul(cz, sy), sx) - q15_mul(sz, cx);
    m[0][2] = q15_mul(q15_mul(cz, sy), cx) + q15_mul(sz, sx);
    m[1][0] = q15_mul(sz, cy);
    m[1][1] = q15_mul(q15_mul(sz, sy), sx) + q15_mul(cz, cx);
    m[1][2] = q15_mul(q15_mul(sz, sy), cx) - q15_mul(cz, sx);
    m[2][0] = -sy;
    m[2][1] = q15_mul(cy, sx);
    m[2][2] = q15_mul(cy, cx);
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int i = 0; i < 3; i++)
      r[i] = clamp32(round_q(v[0] * m[i][0] + v[1] * m[i][1] + v[2] * m[i][2], 15));
    den = longint'({32'd0, cur_focal}) + r[2];
    o.rx = int'(r[0]);
    o.ry = int'(r[1]);
    o.rz = int'(r[2]);
    o.zd = (den == 0);
    if (o.zd) begin
      o.px = 32'h7FFFFFFF;
      o.py = 32'h7FFFFFFF;
    end else begin
      o.px = int'(clamp32((r[0] * longint'({32'd0, cur_focal})) / den));
      o.py = int'(clamp32((r[1] * longint'({32'd0, cur_focal})) / den));
    end
    return o;
  endfunction

  task automatic send_vertex(int vx, int vy, int vz);
    int r;
    push <= 1'b1;
    in_x <= vx;
    in_y <= vy;
    in_z <= vz;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.insert(expected_q.size(), transform_vertex(vx, vy, vz));
    beats_in++;
    r = $urandom_range(0, 99);
    if (!no_idle && r >= 65) begin
      push <= 1'b0;
      repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ANGLE_X: cur_ax = val[15:0];
      REG_ANGLE_Y: cur_ay = val[15:0];
      REG_ANGLE_Z: cur_az = val[15:0];
      REG_FOCAL:   cur_focal = val;
      default:     ;
    endcase
  endtask

  task automatic setup(logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [31:0] f);
    drain();
    program_reg(REG_ANGLE_X, {16'hFFFF, ax});
    program_reg(REG_ANGLE_Y, {16'hA5A5, ay});
    program_reg(REG_ANGLE_Z, {16'h5A5A, az});
    program_reg(REG_FOCAL, f);
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return int'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
    if (r < 90) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_vertex(0, 0, 0);
    send_vertex(32'sh00640000, 32'shFF9C0000, 32'sh00320000);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 0);
  endtask

  task automatic test_zero_depth;
    setup(16'd0, 16'd0, 16'd0, 32'h00010000);
    send_vertex(32'sh00050000, 32'shFFFB0000, 32'shFFFF0000);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'shFFFF0000);
    send_vertex(32'sh00030000, 32'sh00040000, 32'shFFFF0001);
    setup(16'd0, 16'd0, 16'd0, 32'h0);
    send_vertex(32'sh00050000, 32'sh00070000, 0);
    send_vertex(32'sh00050000, 32'sh00070000, 32'sh00010000);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
  endtask

  task automatic test_extremes;
    setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vertex(32'sh12345678, 32'shEDCBA987, 32'sh00000001);
    setup(16'h4000, 16'h8000, 16'hC000, 32'h00000001);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_vertex(-1, -1, -1);
    setup(16'h2000, 16'h6000, 16'hA000, 32'h80000000);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
  endtask

  task automatic test_back_pressure;
    drain();
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    no_idle = 1'b1;
    repeat (120) send_vertex(pick_coord(), pick_coord(), pick_coord());
    no_idle = 1'b0;
  endtask

  task automatic test_random_settings;
    logic [31:0] f;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 2))
        0: f = $urandom_range(32'h00010000, 32'h04000000);
        1: f = $urandom;
        default: f = $urandom_range(1, 32'h0000FFFF);
      endcase
      setup(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535)), f);
      no_idle = (ph == 2);
      repeat (280) send_vertex(pick_coord(), pick_coord(), pick_coord());
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      pop <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (stall_req) begin
      pop <= 1'b0;
      hold_cnt <= 300;
    end else if (pop_gap > 0 && !no_idle) begin
      pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      pop <= 1'b1;
      pop_gap <= (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    vertex_out_t e;
    if (!rst && pop && !empty) begin
      beats_out++;
      if (zero_depth) zero_depth_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result beat rot_x=%0d", rot_x);
      end else begin
        e = expected_q.pop_front();
        if (rot_x !== e.rx || rot_y !== e.ry || rot_z !== e.rz || proj_x !== e.px ||
            proj_y !== e.py || zero_depth !== e.zd) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch exp rot=%0d,%0d,%0d proj=%0d,%0d zd=%0b",
                     e.rx, e.ry, e.rz, e.px, e.py, e.zd);
            $display("         got rot=%0d,%0d,%0d proj=%0d,%0d zd=%0b",
                     rot_x, rot_y, rot_z, proj_x, proj_y, zero_depth);
          end
        end
      end
    end
    if (!rst && ((push && !full) || (pop && !empty))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("vertex_rotate_project verification failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < ROM_DEPTH; k++) sine_tab[k] = sine_entry(k);
    cur_ax = 16'd182;
    cur_ay = 16'd182;
    cur_az = 16'd182;
    cur_focal = 32'd26214400;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_depth();
    test_extremes();
    test_back_pressure();
    test_random_settings();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_q.size() != 0) mismatches += expected_q.size();
    $display("%0d vertices in, %0d results out, %0d with zero depth, over 12 settings",
             beats_in, beats_out, zero_depth_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("vertex_rotate_project verification clean");
    end else begin
      $display("vertex_rotate_project verification failed");
    end
    $finish;
  end

endmodule
